FILE: src/cat_pkg.sv
// shared types, constants and helpers for the connection admission tracker
// no dependencies
package cat_pkg;

    localparam int KEY_W           = 32;
    localparam int COUNT_W         = 16;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int DEFAULT_BUCKETS = 256;
    localparam int DEFAULT_WAYS    = 4;
    localparam int MOD_STEP        = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_SOURCE = 2'd1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TOTAL   = 3'd1,
        ST_SOURCE  = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_FULL    = 3'd4,
        ST_DUP     = 3'd5
    } status_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] source;
    } sess_ent_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } src_ent_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_dec(input logic [COUNT_W-1:0] v);
        return (v == '0) ? v : v - COUNT_W'(1);
    endfunction

endpackage

FILE: src/cat_ram.sv
// simple dual-port row memory, one write and one registered read per cycle
// depends on cat_pkg
module cat_ram
    import cat_pkg::*;
#(
    parameter int WIDTH = KEY_W,
    parameter int DEPTH = DEFAULT_BUCKETS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/cat_mod.sv
// key modulo bucket count: a mask for a power of two, else MOD_STEP key bits a cycle
// depends on cat_pkg
module cat_mod
    import cat_pkg::*;
#(
    parameter int BUCKETS = DEFAULT_BUCKETS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [KEY_W-1:0]           key,
    output logic                       done,
    output logic [$clog2(BUCKETS)-1:0] rem
);

    localparam int  AW   = $clog2(BUCKETS);
    localparam bit  POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

    generate
        if (POW2)
        begin : g_mask
            logic          done_reg;
            logic [AW-1:0] rem_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= key[AW-1:0];
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
        else
        begin : g_iter
            localparam int NSTEP = KEY_W / MOD_STEP;
            localparam int CW    = $clog2(NSTEP);

            logic             busy_reg;
            logic             done_reg;
            logic [CW-1:0]    cnt_reg;
            logic [KEY_W-1:0] shift_reg;
            logic [AW:0]      r_reg;
            logic [AW:0]      r_next;

            // shift in MOD_STEP bits, reducing after each one
            always_comb
            begin
                r_next = r_reg;
                for (int i = 0; i < MOD_STEP; i++)
                begin
                    r_next = {r_next[AW-1:0], shift_reg[KEY_W-1-i]};
                    if (r_next >= (AW+1)'(BUCKETS))
                    begin
                        r_next = r_next - (AW+1)'(BUCKETS);
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    done_reg <= busy_reg && (cnt_reg == CW'(NSTEP - 1));
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= '0;
                    end
                    else if (busy_reg)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                        if (cnt_reg == CW'(NSTEP - 1))
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    shift_reg <= key;
                    r_reg     <= '0;
                end
                else if (busy_reg)
                begin
                    shift_reg <= shift_reg << MOD_STEP;
                    r_reg     <= r_next;
                end
            end

            assign done = done_reg;
            assign rem  = r_reg[AW-1:0];
        end
    endgenerate

endmodule

FILE: src/connection_admission_tracker_top.sv
// connection admission tracker: session and per-source tables in row memories
// depends on cat_pkg, cat_ram, cat_mod
// open: hash the session id and source and read both rows; a live close also
// hashes its owner source and reads that row; with a bucket count that is not a
// power of two each hash takes the 32-bit key 4 bits a cycle; one at a time, an item
// waits for the hash, the registered row read and, on close, the second table read
// reset: a clearing pass writes BUCKETS rows, one a cycle, before the first item
module connection_admission_tracker_top
    import cat_pkg::*;
#(
    parameter int BUCKETS = DEFAULT_BUCKETS,
    parameter int WAYS    = DEFAULT_WAYS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [KEY_W-1:0]     source_address,
    input  logic [KEY_W-1:0]     session_id,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [COUNT_W-1:0]   total_now,
    output logic [COUNT_W-1:0]   source_now
);

    localparam int AW     = $clog2(BUCKETS);
    localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SESS_W = WAYS * $bits(sess_ent_t);
    localparam int SRC_W  = WAYS * $bits(src_ent_t);

    // one-hot sequencer
    typedef enum logic [5:0] {
        S_CLR   = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_LOOK  = 6'b001000,
        S_HASH2 = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [CFG_W-1:0]   max_total_reg;
    logic [CFG_W-1:0]   max_src_reg;
    logic [COUNT_W-1:0] total_reg;

    // latched item
    logic               act_reg;
    logic [KEY_W-1:0]   addr_reg;
    logic [KEY_W-1:0]   id_reg;
    logic [KEY_W-1:0]   owner_reg;
    logic [WW-1:0]      sway_reg;
    logic [AW-1:0]      id_row_reg;
    logic [AW-1:0]      src_row_reg;

    // output register
    logic               out_valid_reg;
    status_t            status_reg;
    logic [COUNT_W-1:0] tot_out_reg;
    logic [COUNT_W-1:0] src_out_reg;

    // hash units
    logic               id_done;
    logic [AW-1:0]      id_rem;
    logic               src_done;
    logic [AW-1:0]      src_rem;
    logic               src_start;
    logic [KEY_W-1:0]   src_hkey;

    // memories
    sess_ent_t [WAYS-1:0] sess_rd;
    sess_ent_t [WAYS-1:0] sess_wd;
    src_ent_t  [WAYS-1:0] src_rd;
    src_ent_t  [WAYS-1:0] src_wd;
    logic                 sess_we;
    logic                 src_we;
    logic [AW-1:0]        sess_wa;
    logic [AW-1:0]        src_wa;
    logic                 sess_re;
    logic                 src_re;

    // lookup results
    logic               accept;
    logic               can_done;
    logic               s_hit;
    logic [WW-1:0]      s_way;
    logic               s_free;
    logic [WW-1:0]      f_way;
    logic               p_hit;
    logic [WW-1:0]      p_way;
    logic               q_free;
    logic [WW-1:0]      q_free_way;
    logic [WW-1:0]      q_way;
    logic [KEY_W-1:0]   src_sel;
    logic               full;
    logic [COUNT_W-1:0] src_cur;
    logic [COUNT_W-1:0] tot_inc;
    logic [COUNT_W-1:0] cnt_inc;
    logic [COUNT_W-1:0] cnt_dec;
    status_t            open_st;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    // a result may land when the output register is empty or being drained
    assign can_done = !out_valid_reg || !out_stall;

    assign src_start = accept || ((state_reg == S_LOOK) && act_reg && s_hit);
    assign src_hkey  = accept ? source_address : sess_rd[s_way].source;

    cat_mod #(.BUCKETS(BUCKETS)) u_id_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (session_id),
        .done  (id_done),
        .rem   (id_rem)
    );

    cat_mod #(.BUCKETS(BUCKETS)) u_src_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (src_start),
        .key   (src_hkey),
        .done  (src_done),
        .rem   (src_rem)
    );

    assign sess_re = (state_reg == S_HASH) && id_done;
    assign src_re  = ((state_reg == S_HASH) && id_done) ||
                     ((state_reg == S_HASH2) && src_done);

    cat_ram #(.WIDTH(SESS_W), .DEPTH(BUCKETS)) u_sess_ram (
        .clk   (clk),
        .we    (sess_we),
        .waddr (sess_wa),
        .wdata (sess_wd),
        .re    (sess_re),
        .raddr (id_rem),
        .rdata (sess_rd)
    );

    cat_ram #(.WIDTH(SRC_W), .DEPTH(BUCKETS)) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .waddr (src_wa),
        .wdata (src_wd),
        .re    (src_re),
        .raddr (src_rem),
        .rdata (src_rd)
    );

    // way search over the rows that were read
    assign src_sel = (state_reg == S_FIN) ? owner_reg : addr_reg;

    always_comb
    begin
        s_hit      = 1'b0;
        s_way      = '0;
        s_free     = 1'b0;
        f_way      = '0;
        p_hit      = 1'b0;
        p_way      = '0;
        q_free     = 1'b0;
        q_free_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!s_hit && sess_rd[w].valid && (sess_rd[w].key == id_reg))
            begin
                s_hit = 1'b1;
                s_way = WW'(w);
            end
            if (!s_free && !sess_rd[w].valid)
            begin
                s_free = 1'b1;
                f_way  = WW'(w);
            end
            if (!p_hit && (src_rd[w].count != '0) && (src_rd[w].key == src_sel))
            begin
                p_hit = 1'b1;
                p_way = WW'(w);
            end
            if (!q_free && (src_rd[w].count == '0))
            begin
                q_free     = 1'b1;
                q_free_way = WW'(w);
            end
        end
    end

    assign q_way   = p_hit ? p_way : q_free_way;
    assign full    = !s_free || !(p_hit || q_free);
    assign src_cur = p_hit ? src_rd[p_way].count : '0;
    assign tot_inc = sat_inc(total_reg);
    assign cnt_inc = sat_inc(src_rd[q_way].count);
    assign cnt_dec = sat_dec(src_rd[p_way].count);

    // verdict: total limit first, then source limit
    always_comb
    begin
        priority if ((max_total_reg != '0) && (tot_inc > max_total_reg))
        begin
            open_st = ST_TOTAL;
        end
        else if ((max_src_reg != '0) && (cnt_inc > max_src_reg))
        begin
            open_st = ST_SOURCE;
        end
        else
        begin
            open_st = ST_OK;
        end
    end

    // memory write port selection
    always_comb
    begin
        sess_we = 1'b0;
        sess_wa = id_row_reg;
        sess_wd = sess_rd;
        src_we  = 1'b0;
        src_wa  = src_row_reg;
        src_wd  = src_rd;
        unique case (state_reg)
            S_CLR:
            begin
                sess_we = 1'b1;
                sess_wa = clr_cnt_reg;
                sess_wd = '0;
                src_we  = 1'b1;
                src_wa  = clr_cnt_reg;
                src_wd  = '0;
            end
            S_LOOK:
            begin
                if (!act_reg && can_done && !s_hit && !full)
                begin
                    sess_we              = 1'b1;
                    sess_wd[f_way].valid = 1'b1;
                    sess_wd[f_way].key   = id_reg;
                    sess_wd[f_way].source = addr_reg;
                    src_we               = 1'b1;
                    src_wd[q_way].key    = addr_reg;
                    src_wd[q_way].count  = cnt_inc;
                end
            end
            S_FIN:
            begin
                if (can_done)
                begin
                    sess_we                 = 1'b1;
                    sess_wd[sway_reg].valid = 1'b0;
                    src_we                  = p_hit;
                    src_wd[p_way].count     = cnt_dec;
                end
            end
            S_IDLE, S_HASH, S_HASH2:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_total_reg <= '0;
            max_src_reg   <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_MAX_TOTAL)
            begin
                max_total_reg <= cfg_data;
            end
            else if (cfg_index == CFG_MAX_PER_SOURCE)
            begin
                max_src_reg <= cfg_data;
            end
        end
    end

    // sequencer, total count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(BUCKETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (id_done)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (act_reg && s_hit)
                    begin
                        state_reg <= S_HASH2;
                    end
                    else if (can_done)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                        if (!act_reg && !s_hit && !full)
                        begin
                            total_reg <= tot_inc;
                        end
                    end
                end
                S_HASH2:
                begin
                    if (src_done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (can_done)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                        total_reg     <= sat_dec(total_reg);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            addr_reg <= source_address;
            id_reg   <= session_id;
        end
        if (sess_re)
        begin
            id_row_reg <= id_rem;
        end
        if (src_re)
        begin
            src_row_reg <= src_rem;
        end
        if ((state_reg == S_LOOK) && act_reg && s_hit)
        begin
            owner_reg <= sess_rd[s_way].source;
            sway_reg  <= s_way;
        end
        if ((state_reg == S_LOOK) && !(act_reg && s_hit) && can_done)
        begin
            if (act_reg)
            begin
                // close of a session that is not live
                status_reg  <= ST_UNKNOWN;
                tot_out_reg <= total_reg;
                src_out_reg <= '0;
            end
            else if (s_hit)
            begin
                status_reg  <= ST_DUP;
                tot_out_reg <= total_reg;
                src_out_reg <= src_cur;
            end
            else if (full)
            begin
                status_reg  <= ST_FULL;
                tot_out_reg <= total_reg;
                src_out_reg <= src_cur;
            end
            else
            begin
                status_reg  <= open_st;
                tot_out_reg <= tot_inc;
                src_out_reg <= cnt_inc;
            end
        end
        if ((state_reg == S_FIN) && can_done)
        begin
            // owner entry may be missing: then only the total drops
            status_reg  <= ST_OK;
            tot_out_reg <= sat_dec(total_reg);
            src_out_reg <= p_hit ? cnt_dec : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign total_now  = tot_out_reg;
    assign source_now = src_out_reg;

endmodule

FILE: src/cat_checker.sv
// port-level checks for the connection admission tracker, bound to the top level
// depends on cat_pkg and connection_admission_tracker_top
module cat_checker
    import cat_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [2:0]         status,
    input logic [COUNT_W-1:0] total_now,
    input logic [COUNT_W-1:0] source_now
);

    // one item in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an accept");

    a_unknown_no_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_UNKNOWN) |-> source_now == '0)
        else $error("unknown close reports a source count");

    a_limits_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_TOTAL || status == ST_SOURCE)
        |-> total_now != '0 && source_now != '0)
        else $error("refused open with a zero count");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(total_now))
        else $error("stalled result changed");

endmodule

bind connection_admission_tracker_top cat_checker u_cat_checker (.*);

FILE: tb/sv/connection_admission_tracker_top_tb.sv
// self-checking testbench for connection_admission_tracker_top
// depends on cat_pkg and the tracker rtl; predicts each result and compares in order
`timescale 1ns / 100ps
module connection_admission_tracker_top_tb;
    import cat_pkg::*;

    localparam int NBUCKET = DEFAULT_BUCKETS;
    localparam int NWAY    = DEFAULT_WAYS;
    localparam int NENT    = NBUCKET * NWAY;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic OPEN  = 1'b0;
    localparam logic CLOSE = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic             act;
        logic [KEY_W-1:0] addr;
        logic [KEY_W-1:0] sid;
    } conn_item_t;

    typedef struct packed {
        status_t            st;
        logic [COUNT_W-1:0] tot;
        logic [COUNT_W-1:0] src;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = 1'b0;
    logic [KEY_W-1:0] source_address = '0;
    logic [KEY_W-1:0] session_id = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] status;
    logic [COUNT_W-1:0] total_now;
    logic [COUNT_W-1:0] source_now;

    connection_admission_tracker_top dut (.*);

    always #10 clk = ~clk;

    // predictor state: shadow of the tables and limits
    logic [COUNT_W-1:0] lim_total, lim_source, live_total;
    logic               sess_live [NENT];
    logic [KEY_W-1:0]   sess_id_tab [NENT];
    logic [KEY_W-1:0]   sess_owner [NENT];
    logic [KEY_W-1:0]   src_addr_tab [NENT];
    logic [COUNT_W-1:0] src_cnt [NENT];

    conn_item_t pending_items[$];
    verdict_t   expected_verdicts[$];
    int  fail_count = 0;
    bit  quiet_mode = 0;     // no idling in the last part
    bit  hold_sender = 0;    // sender pauses while set
    int  idle_cycles = 0;

    function automatic int set_of(logic [KEY_W-1:0] k);
        return int'(k % NBUCKET) * NWAY;
    endfunction

    function automatic int lookup_session(logic [KEY_W-1:0] id);
        for (int w = 0; w < NWAY; w++)
            if (sess_live[set_of(id)+w] && sess_id_tab[set_of(id)+w] == id)
                return set_of(id) + w;
        return -1;
    endfunction

    function automatic int lookup_source(logic [KEY_W-1:0] a);
        for (int w = 0; w < NWAY; w++)
            if (src_cnt[set_of(a)+w] != 0 && src_addr_tab[set_of(a)+w] == a)
                return set_of(a) + w;
        return -1;
    endfunction

    // apply one item to the shadow tables and return its verdict
    function automatic verdict_t admit_or_release(conn_item_t it);
        verdict_t v;
        int s, p, f, q;
        v.st = ST_OK;
        v.src = '0;
        s = lookup_session(it.sid);
        if (it.act == OPEN) begin
            p = lookup_source(it.addr);
            if (s >= 0) begin
                v.st = ST_DUP;
                v.src = (p >= 0) ? src_cnt[p] : '0;
            end else begin
                f = -1;
                for (int w = NWAY - 1; w >= 0; w--)
                    if (!sess_live[set_of(it.sid)+w]) f = set_of(it.sid) + w;
                q = p;
                if (q < 0)
                    for (int w = NWAY - 1; w >= 0; w--)
                        if (src_cnt[set_of(it.addr)+w] == 0) q = set_of(it.addr) + w;
                if (f < 0 || q < 0) begin
                    v.st = ST_FULL;
                    v.src = (p >= 0) ? src_cnt[p] : '0;
                end else begin
                    sess_live[f] = 1'b1;
                    sess_id_tab[f] = it.sid;
                    sess_owner[f] = it.addr;
                    src_addr_tab[q] = it.addr;
                    if (src_cnt[q] != '1) src_cnt[q]++;
                    if (live_total != '1) live_total++;
                    v.src = src_cnt[q];
                    if (lim_total != 0 && live_total > lim_total) v.st = ST_TOTAL;
                    else if (lim_source != 0 && v.src > lim_source) v.st = ST_SOURCE;
                end
            end
        end else if (s < 0) begin
            v.st = ST_UNKNOWN;
        end else begin
            p = lookup_source(sess_owner[s]);
            if (live_total != 0) live_total--;
            if (p >= 0) begin
                if (src_cnt[p] != 0) src_cnt[p]--;
                v.src = src_cnt[p];
            end
            sess_live[s] = 1'b0;
        end
        v.tot = live_total;
        return v;
    endfunction

    // driver: one item per handshake, random gaps
    int gap_left = 0;
    always @(posedge clk) begin
        if (in_valid && !in_stall) begin
            expected_verdicts.push_back(admit_or_release(
                conn_item_t'{action, source_address, session_id}));
            void'(pending_items.pop_front());
        end
        if (in_valid && in_stall) begin
            // hold the stalled item
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            in_valid <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            gap_left <= $urandom_range(0, 7);
            in_valid <= 1'b0;
        end else if (!hold_sender && pending_items.size() > 0)
        begin
            // the accepted item has already left the queue
            conn_item_t nx;
            nx = pending_items[0];
            in_valid <= 1'b1;
            action <= nx.act;
            source_address <= nx.addr;
            session_id <= nx.sid;
        end else begin
            in_valid <= 1'b0;
        end
    end

    // monitor and receiver stall
    int stall_left = 0;
    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            verdict_t want;
            if (expected_verdicts.size() == 0) begin
                $display("%0t unexpected result status=%0d total=%0d source=%0d",
                         $time, status, total_now, source_now);
                fail_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (status !== want.st)
                    begin $display("%0t status expected %0d actual %0d", $time, want.st, status);
                    fail_count++; end
                if (total_now !== want.tot)
                    begin $display("%0t total_now expected %0d actual %0d", $time, want.tot,
                                   total_now); fail_count++; end
                if (source_now !== want.src)
                    begin $display("%0t source_now expected %0d actual %0d", $time, want.src,
                                   source_now); fail_count++; end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 7);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_item(logic a, logic [KEY_W-1:0] addr, logic [KEY_W-1:0] sid);
        pending_items.push_back(conn_item_t'{a, addr, sid});
    endtask

    // wait until everything sent has come back
    task automatic drain();
        wait (pending_items.size() == 0 && !in_valid);
        wait (expected_verdicts.size() == 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_MAX_TOTAL) lim_total = val;
        else if (idx == CFG_MAX_PER_SOURCE) lim_source = val;
    endtask

    // random phase: mostly opens and closes of tracked sessions from few sources
    task automatic random_phase(int n, int nsrc);
        logic [KEY_W-1:0] open_ids[$];
        logic [KEY_W-1:0] srcs[8];
        logic [KEY_W-1:0] sid;
        int k, r;
        for (int i = 0; i < 8; i++)
            srcs[i] = (i < nsrc) ? $urandom() : srcs[0];
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50 || open_ids.size() == 0) begin
                sid = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2047);
                open_ids.push_back(sid);
                push_item(OPEN, srcs[$urandom_range(0, nsrc - 1)], sid);
            end else if (r < 88) begin
                k = $urandom_range(0, open_ids.size() - 1);
                push_item(CLOSE, $urandom(), open_ids[k]);
                open_ids.delete(k);
            end else if (r < 94) begin
                push_item(OPEN, $urandom(), open_ids[$urandom_range(0, open_ids.size() - 1)]);
            end else begin
                push_item(CLOSE, $urandom(), $urandom());
            end
        end
    endtask

    initial begin
        lim_total = 0;
        lim_source = 0;
        live_total = 0;
        for (int i = 0; i < NENT; i++) begin
            sess_live[i] = 1'b0;
            src_cnt[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (NBUCKET + 4) @(posedge clk);

        // directed: extremes, duplicates, unknown close, full sets, limits
        write_limit(CFG_MAX_TOTAL, 16'd3);
        write_limit(CFG_MAX_PER_SOURCE, 16'd2);
        write_limit(CFG_UNUSED, 16'hFFFF);
        push_item(OPEN, 32'h0000_0000, 32'h0000_0000);
        push_item(OPEN, 32'h0000_0000, 32'h0000_0000);   // duplicate
        push_item(OPEN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(OPEN, 32'h0000_0000, 32'h0000_0100);   // source reaches its limit
        push_item(OPEN, 32'hFFFF_FFFF, 32'h0000_0200);   // total over limit
        push_item(OPEN, 32'h1234_5678, 32'h0000_0300);   // takes the last free way of its session set
        push_item(CLOSE, 32'h0, 32'hDEAD_BEEF);          // unknown session
        push_item(CLOSE, 32'h0, 32'h0000_0000);
        push_item(CLOSE, 32'h0, 32'h0000_0000);          // already closed
        push_item(CLOSE, 32'h0, 32'h0000_0100);          // source entry freed
        // fill one source set with four addresses, a fifth finds it full
        for (int i = 0; i < 5; i++)
            push_item(OPEN, 32'h0000_0007 + 32'(i * NBUCKET), 32'h0001_0000 + 32'(i));
        push_item(OPEN, 32'h0000_0007, 32'h0002_0000);   // existing source reused
        push_item(OPEN, 32'hAAAA_5555, 32'h5555_AAAA);
        push_item(CLOSE, 32'h0, 32'hFFFF_FFFF);
        drain();

        // pressure: the queue fills while the sender is held, then drains once it is released
        hold_sender = 1;
        random_phase(60, 4);
        repeat (20) @(posedge clk);
        hold_sender = 0;
        drain();

        write_limit(CFG_MAX_TOTAL, 16'd0);
        write_limit(CFG_MAX_PER_SOURCE, 16'd0);
        random_phase(600, 8);
        drain();

        write_limit(CFG_MAX_TOTAL, 16'hFFFF);
        write_limit(CFG_MAX_PER_SOURCE, 16'd1);
        random_phase(500, 3);
        drain();

        write_limit(CFG_MAX_TOTAL, 16'd20);
        write_limit(CFG_MAX_PER_SOURCE, 16'hFFFF);
        random_phase(400, 2);
        drain();

        // last part: no idling on either side
        quiet_mode = 1;
        write_limit(CFG_MAX_TOTAL, 16'd40);
        write_limit(CFG_MAX_PER_SOURCE, 16'd10);
        random_phase(300, 5);
        drain();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/cat_pkg.sv
src/cat_ram.sv
src/cat_mod.sv
src/connection_admission_tracker_top.sv
src/cat_checker.sv
tb/sv/connection_admission_tracker_top_tb.sv
